/* hw/rtl/rhp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and codes for the RTP header parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

  localparam logic [3:0] CODE_ELEMENT   = 4'd0;
  localparam logic [3:0] CODE_OK        = 4'd1;
  localparam logic [3:0] CODE_TOO_LONG  = 4'd2;
  localparam logic [3:0] CODE_NOT_RTP   = 4'd3;
  localparam logic [3:0] CODE_CSRC      = 4'd4;
  localparam logic [3:0] CODE_XHDR      = 4'd5;
  localparam logic [3:0] CODE_XVAL      = 4'd6;
  localparam logic [3:0] CODE_NO_PAD    = 4'd7;
  localparam logic [3:0] CODE_PAD_ZERO  = 4'd8;
  localparam logic [3:0] CODE_PAD_BIG   = 4'd9;

  localparam logic [15:0] MAX_BYTES_RESET = 16'd1500;
  localparam logic [15:0] PROFILE_ONE_BYTE = 16'hBEDE;
  localparam logic [11:0] PROFILE_TWO_BYTE = 12'h100;

  typedef struct packed {
    logic [3:0]  result_code;
    logic [7:0]  ext_id;
    logic [15:0] ext_offset;
    logic [7:0]  ext_length;
    logic [6:0]  payload_type;
    logic        marker;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] source_id;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [7:0]  padding_length;
  } result_t;

  // Words produced by one input byte: up to two, element first.
  typedef struct packed {
    logic [1:0] count;
    result_t    word0;
    result_t    word1;
  } push_t;

endpackage

`default_nettype wire

/* hw/rtl/rhp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_front
// Byte-wise packet walker: header capture, extension walk and verdict.
// ----------------------------------------------------------------------------
module rhp_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic [15:0]    cfg_wr_data,
  input  wire logic           take,
  input  wire logic [7:0]     byte_value,
  input  wire logic           is_last,
  output rhp_pkg::push_t      push
);
  import rhp_pkg::*;

  localparam logic [2:0] PH_FIXED   = 3'd0;
  localparam logic [2:0] PH_CSRC    = 3'd1;
  localparam logic [2:0] PH_XHDR    = 3'd2;
  localparam logic [2:0] PH_WALK    = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_SINK    = 3'd6;

  localparam logic [3:0] FAIL_NONE  = 4'd0;

  logic [15:0] max_r;
  logic [15:0] cnt_r, cnt_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [31:0] src_r, src_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [15:0] prof_r, prof_nxt;
  logic [16:0] aend_r, aend_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [16:0] hend_r, hend_nxt;
  logic [3:0]  fail_r, fail_nxt;

  logic [16:0] pos1;
  logic [16:0] idx;
  logic [15:0] words;
  logic [18:0] xend;
  logic [3:0]  nib_id;
  logic [4:0]  nib_len;
  logic        el_valid;
  logic [7:0]  el_id;
  logic [7:0]  el_len;
  logic [7:0]  b0;
  logic [6:0]  csrc_end;
  logic [15:0] plen;
  logic [3:0]  code;
  result_t     el_w, vd_w;

  assign pos1    = {1'b0, cnt_r} + 17'd1;
  assign idx     = {1'b0, cnt_r} - hend_r;
  assign words   = {aend_r[7:0], byte_value};
  assign xend    = {2'b00, hend_r} + 19'd4 + {1'b0, words, 2'b00};
  assign nib_id  = byte_value[7:4];
  assign nib_len = {1'b0, byte_value[3:0]} + 5'd1;

  always_comb begin
    cnt_nxt  = cnt_r;
    hdr_nxt  = hdr_r;
    src_nxt  = src_r;
    ph_nxt   = ph_r;
    prof_nxt = prof_r;
    aend_nxt = aend_r;
    rem_nxt  = rem_r;
    pend_nxt = pend_r;
    hend_nxt = hend_r;
    fail_nxt = fail_r;
    el_valid = 1'b0;
    el_id    = '0;
    el_len   = '0;
    if (cnt_r == 16'hFFFF) begin
      fail_nxt = CODE_TOO_LONG;
    end else begin
      cnt_nxt = cnt_r + 16'd1;
    end
    case (ph_r)
      PH_FIXED: begin
        if (cnt_r < 16'd8) begin
          hdr_nxt = {hdr_r[55:0], byte_value};
        end else begin
          src_nxt = {src_r[23:0], byte_value};
        end
        if (cnt_r == 16'd0 && byte_value[7:6] != 2'b10) begin
          if (fail_r == FAIL_NONE) fail_nxt = CODE_NOT_RTP;
          ph_nxt = PH_SINK;
        end else if (cnt_r == 16'd11) begin
          hend_nxt = 17'd12 + {11'd0, hdr_r[59:56], 2'b00};
          if (hdr_r[59:56] != 4'd0) ph_nxt = PH_CSRC;
          else if (hdr_r[60]) ph_nxt = PH_XHDR;
          else ph_nxt = PH_PAYLOAD;
        end
      end
      PH_CSRC: begin
        if (pos1 >= hend_r) ph_nxt = hdr_r[60] ? PH_XHDR : PH_PAYLOAD;
      end
      PH_XHDR: begin
        if (idx < 17'd2) begin
          prof_nxt = {prof_r[7:0], byte_value};
        end else if (idx == 17'd2) begin
          aend_nxt = {9'd0, byte_value};
        end else begin
          aend_nxt = (xend > 19'h1FFFF) ? 17'h1FFFF : xend[16:0];
          hend_nxt = aend_nxt;
          rem_nxt  = '0;
          pend_nxt = '0;
          ph_nxt   = (words != 16'd0) ? PH_WALK : PH_PAYLOAD;
        end
      end
      PH_WALK: begin
        if (rem_r != 9'd0) begin
          rem_nxt = rem_r - 9'd1;
        end else if (pend_r != 8'd0) begin
          if ({1'b0, pos1} + {10'd0, byte_value} > {1'b0, aend_r}) begin
            ph_nxt = PH_SKIP;
          end else begin
            el_valid = 1'b1;
            el_id    = pend_r;
            el_len   = byte_value;
            rem_nxt  = {1'b0, byte_value};
          end
          pend_nxt = '0;
        end else if (prof_r == PROFILE_ONE_BYTE) begin
          if (nib_id == 4'd15) begin
            ph_nxt = PH_SKIP;
          end else if (nib_id != 4'd0) begin
            if ({1'b0, pos1} + {13'd0, nib_len} > {1'b0, aend_r}) begin
              ph_nxt = PH_SKIP;
            end else begin
              el_valid = 1'b1;
              el_id    = {4'd0, nib_id};
              el_len   = {3'd0, nib_len};
              rem_nxt  = {4'd0, nib_len};
            end
          end
        end else if (prof_r[15:4] == PROFILE_TWO_BYTE) begin
          pend_nxt = byte_value;
        end else begin
          ph_nxt = PH_SKIP;
        end
        if (pos1 >= aend_r) ph_nxt = PH_PAYLOAD;
      end
      PH_SKIP: begin
        if (pos1 >= aend_r) ph_nxt = PH_PAYLOAD;
      end
      default: begin
      end
    endcase
  end

  // Verdict on the updated packet state.
  assign b0       = hdr_nxt[63:56];
  assign csrc_end = 7'd12 + {1'b0, b0[3:0], 2'b00};

  always_comb begin
    plen = cnt_nxt - hend_nxt[15:0];
    if (fail_nxt == CODE_TOO_LONG || cnt_nxt > max_r) begin
      code = CODE_TOO_LONG;
    end else if (fail_nxt == CODE_NOT_RTP || cnt_nxt < 16'd12) begin
      code = CODE_NOT_RTP;
    end else if (cnt_nxt < {9'd0, csrc_end}) begin
      code = CODE_CSRC;
    end else if (b0[4] && cnt_nxt < {9'd0, csrc_end} + 16'd4) begin
      code = CODE_XHDR;
    end else if (b0[4] && {1'b0, cnt_nxt} < hend_nxt) begin
      code = CODE_XVAL;
    end else if (b0[5] && plen == 16'd0) begin
      code = CODE_NO_PAD;
    end else if (b0[5] && byte_value == 8'd0) begin
      code = CODE_PAD_ZERO;
    end else if (b0[5] && plen < {8'd0, byte_value}) begin
      code = CODE_PAD_BIG;
    end else begin
      code = CODE_OK;
    end
  end

  always_comb begin
    el_w             = '0;
    el_w.result_code = CODE_ELEMENT;
    el_w.ext_id      = el_id;
    el_w.ext_offset  = pos1[15:0];
    el_w.ext_length  = el_len;
    vd_w             = '0;
    vd_w.result_code = code;
    if (code == CODE_OK) begin
      vd_w.payload_type   = hdr_nxt[54:48];
      vd_w.marker         = hdr_nxt[55];
      vd_w.sequence_res   = hdr_nxt[47:32];
      vd_w.timestamp      = hdr_nxt[31:0];
      vd_w.source_id      = src_nxt;
      vd_w.payload_offset = hend_nxt[15:0];
      vd_w.payload_length = b0[5] ? plen - {8'd0, byte_value} : plen;
      vd_w.padding_length = b0[5] ? byte_value : 8'd0;
    end
    push.count = take ? ({1'b0, el_valid} + {1'b0, is_last}) : 2'd0;
    push.word0 = el_valid ? el_w : vd_w;
    push.word1 = vd_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_BYTES_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && is_last)) begin
      cnt_r  <= '0;
      hdr_r  <= '0;
      src_r  <= '0;
      ph_r   <= PH_FIXED;
      prof_r <= '0;
      aend_r <= '0;
      rem_r  <= '0;
      pend_r <= '0;
      hend_r <= '0;
      fail_r <= '0;
    end else if (take) begin
      cnt_r  <= cnt_nxt;
      hdr_r  <= hdr_nxt;
      src_r  <= src_nxt;
      ph_r   <= ph_nxt;
      prof_r <= prof_nxt;
      aend_r <= aend_nxt;
      rem_r  <= rem_nxt;
      pend_r <= pend_nxt;
      hend_r <= hend_nxt;
      fail_r <= fail_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rhp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rhp_queue
// Result queue: takes up to two words a cycle, hands out one.
// ----------------------------------------------------------------------------
module rhp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rhp_pkg::push_t push,
  input  wire logic           pop,
  output logic                full,
  output logic                empty,
  output rhp_pkg::result_t    head
);
  import rhp_pkg::*;

  localparam int AW = $clog2(DEPTH);

  result_t     mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r, wp1;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_pop;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r > (AW+1)'(DEPTH - 2));
  assign head   = mem_r[rp_r];
  assign do_pop = pop && !empty;
  assign wp1    = wp_r + AW'(1);
  assign cnt_nxt = cnt_r + {{(AW-1){1'b0}}, push.count} - {{AW{1'b0}}, do_pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wp_r] <= push.word0;
    if (push.count == 2'd2) mem_r[wp1] <= push.word1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(push.count);
      if (do_pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rtp_header_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_header_parser_top
// Streaming RTP header and header-extension parser.
// ----------------------------------------------------------------------------
// Feed one packet byte per word on the in_ side; the front walker handles
// every byte in the cycle it is accepted, so a packet streams at one byte per
// clock while in_full is low. Each byte yields zero, one or two result words
// (an element word when an extension element header completes, a verdict word
// on the last byte); these go into a small result queue read from the out_
// side. in_full rises while the queue has fewer than two free slots, so the
// input only stalls when the consumer falls behind. A result word is queued
// the cycle after its byte is taken. Write cfg_wr_data with cfg_wr_en to set
// the longest accepted packet; write it only between packets.
// QUEUE_DEPTH must be a power of two, at least 4.
// ----------------------------------------------------------------------------
module rtp_header_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_is_last,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [3:0]       out_result_code,
  output logic [7:0]       out_ext_id,
  output logic [15:0]      out_ext_offset,
  output logic [7:0]       out_ext_length,
  output logic [6:0]       out_payload_type,
  output logic             out_marker,
  output logic [15:0]      out_sequence_res,
  output logic [31:0]      out_timestamp,
  output logic [31:0]      out_source_id,
  output logic [15:0]      out_payload_offset,
  output logic [15:0]      out_payload_length,
  output logic [7:0]       out_padding_length
);
  import rhp_pkg::*;

  push_t   push;
  result_t head;
  logic    take;

  // Accept a byte only when the queue can hold two more words.
  assign take = in_push && !in_full;

  rhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .take       (take),
    .byte_value (in_byte_value),
    .is_last    (in_is_last),
    .push       (push)
  );

  rhp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (out_pop),
    .full (in_full),
    .empty(out_empty),
    .head (head)
  );

  // Drive the oldest waiting word.
  assign out_result_code    = head.result_code;
  assign out_ext_id         = head.ext_id;
  assign out_ext_offset     = head.ext_offset;
  assign out_ext_length     = head.ext_length;
  assign out_payload_type   = head.payload_type;
  assign out_marker         = head.marker;
  assign out_sequence_res   = head.sequence_res;
  assign out_timestamp      = head.timestamp;
  assign out_source_id      = head.source_id;
  assign out_payload_offset = head.payload_offset;
  assign out_payload_length = head.payload_length;
  assign out_padding_length = head.padding_length;

endmodule

`default_nettype wire
